FILE: sv/xtsd_pkg.sv
// ----------------------------------------------------------------------------
// xtsd_pkg
// Shared commands, constants and control types of the table-keyed stream
// decryptor.
// ----------------------------------------------------------------------------
`default_nettype none

package xtsd_pkg;

	localparam int unsigned DATA_W   = 32;
	localparam int unsigned TABLE_N  = 256;
	localparam int unsigned TABLE_AW = 8;

	localparam logic [31:0] KEY_WHITEN = 32'h5555_5555;
	localparam logic [31:0] TABLE_MULT = 32'd39916801;

	localparam logic [1:0] CMD_LOAD     = 2'd0;
	localparam logic [1:0] CMD_WORD_UPD = 2'd1;
	localparam logic [1:0] CMD_BYTE_UPD = 2'd2;
	localparam logic [1:0] CMD_WORD     = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic build_step;
		logic read_step;
		logic push;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic go_build;
		logic go_read;
		logic build_last;
		logic read_last;
	} sts_t;

endpackage

`default_nettype wire

FILE: sv/xtsd_if.sv
// ----------------------------------------------------------------------------
// xtsd_cmd_if / xtsd_res_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface xtsd_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [31:0] cipher_data;

	modport source (output valid, command, cipher_data, input ready);
	modport sink (input valid, command, cipher_data, output ready);
endinterface

interface xtsd_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] plain_data;
	logic        no_key;

	modport source (output valid, plain_data, no_key, input ready);
	modport sink (input valid, plain_data, no_key, output ready);
endinterface

`default_nettype wire

FILE: sv/xor_table_stream_decryptor.sv
// A word without update, or an item before any key, goes straight to the output
// register; a byte with update reads one table lane, a word with update reads
// all four lanes, and a key load first builds all 256 table entries.
// The next item is accepted once the previous one has been handed to the output
// register; one table read port reads one lane a cycle and one multiplier
// builds one entry a cycle. Reset clears the key, the loaded flag and control.
// ----------------------------------------------------------------------------
// xor_table_stream_decryptor
// Stream decryptor with a self-updating XOR key and a 256-entry key table.
// ----------------------------------------------------------------------------
`default_nettype none

module xor_table_stream_decryptor (
	input wire logic clk,
	input wire logic arst_n,
	xtsd_cmd_if.sink   cmd_ch,
	xtsd_res_if.source res_ch
);

	xtsd_pkg::ctl_t ctl;
	xtsd_pkg::sts_t sts;

	xtsd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd_ch.valid),
		.in_ready  (cmd_ch.ready),
		.out_valid (res_ch.valid),
		.out_ready (res_ch.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	xtsd_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.command     (cmd_ch.command),
		.cipher_data (cmd_ch.cipher_data),
		.ctl         (ctl),
		.sts         (sts),
		.plain_data  (res_ch.plain_data),
		.no_key      (res_ch.no_key)
	);

	// One item in flight: a transfer in is never followed directly by another.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_ch.valid && cmd_ch.ready |=> !cmd_ch.ready)
		else $error("second item accepted while one is in work");

	// A result flagged as keyless carries zero.
	a_nokey_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_ch.valid && res_ch.no_key |-> res_ch.plain_data == 32'd0)
		else $error("keyless result carries data");

	// The table build runs without a break until its last entry.
	a_build_run: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.build_step && !sts.build_last |=> ctl.build_step)
		else $error("table build stopped early");

	// A result is handed over only when the output register is free.
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |-> !res_ch.valid || res_ch.ready)
		else $error("result overwritten before transfer");

endmodule

`default_nettype wire

FILE: sv/xtsd_datapath.sv
// ----------------------------------------------------------------------------
// xtsd_datapath
// Key register, key table memory with its generator, lane reads and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module xtsd_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [1:0]          command,
	input  wire logic [31:0]         cipher_data,
	input  wire xtsd_pkg::ctl_t      ctl,
	output      xtsd_pkg::sts_t      sts,
	output      logic [31:0]         plain_data,
	output      logic                no_key
);

	logic [31:0] key_q;
	logic        loaded_q;
	logic [1:0]  cmd_q;
	logic [31:0] data_q;
	logic [31:0] res_q;
	logic        nk_res_q;
	logic [31:0] gen_q;
	logic [xtsd_pkg::TABLE_AW-1:0] idx_q;
	logic [1:0]  lane_q;
	logic        rdv_q;
	logic [31:0] rd_q;
	logic [31:0] out_plain_q;
	logic        out_nk_q;

	logic [31:0] mem [xtsd_pkg::TABLE_N];

	logic [31:0] gen_rot;
	logic [31:0] gen_next;
	logic [xtsd_pkg::TABLE_AW-1:0] rd_addr;
	logic [31:0] wk;

	assign gen_rot  = {gen_q[0], gen_q[31:1]};
	assign gen_next = 32'(gen_rot * xtsd_pkg::TABLE_MULT);
	assign rd_addr  = data_q[{lane_q, 3'b000} +: xtsd_pkg::TABLE_AW];
	assign wk       = cipher_data ^ key_q;

	assign sts.go_build   = (command == xtsd_pkg::CMD_LOAD);
	assign sts.go_read    = loaded_q && ((command == xtsd_pkg::CMD_WORD_UPD) ||
	                                     (command == xtsd_pkg::CMD_BYTE_UPD));
	assign sts.build_last = (idx_q == {xtsd_pkg::TABLE_AW{1'b1}});
	assign sts.read_last  = (cmd_q == xtsd_pkg::CMD_BYTE_UPD) || (lane_q == 2'd3);

	assign plain_data = out_plain_q;
	assign no_key     = out_nk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q    <= '0;
			loaded_q <= 1'b0;
			rdv_q    <= 1'b0;
		end else begin
			rdv_q <= ctl.read_step;
			if (ctl.capture && sts.go_build) begin
				key_q    <= cipher_data ^ xtsd_pkg::KEY_WHITEN;
				loaded_q <= 1'b1;
			end else if (rdv_q) begin
				// The plaintext already used the old key at capture.
				key_q <= key_q ^ rd_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q  <= command;
			data_q <= cipher_data;
			gen_q  <= cipher_data ^ xtsd_pkg::KEY_WHITEN;
			idx_q  <= '0;
			lane_q <= '0;
			if (command == xtsd_pkg::CMD_LOAD) begin
				res_q    <= cipher_data ^ xtsd_pkg::KEY_WHITEN;
				nk_res_q <= 1'b0;
			end else if (!loaded_q) begin
				res_q    <= '0;
				nk_res_q <= 1'b1;
			end else if (command == xtsd_pkg::CMD_BYTE_UPD) begin
				res_q    <= {24'd0, wk[7:0]};
				nk_res_q <= 1'b0;
			end else begin
				res_q    <= wk;
				nk_res_q <= 1'b0;
			end
		end else begin
			if (ctl.build_step) begin
				gen_q <= gen_next;
				idx_q <= idx_q + 1'b1;
			end
			if (ctl.read_step) begin
				lane_q <= lane_q + 1'b1;
			end
		end
		if (ctl.push) begin
			out_plain_q <= res_q;
			out_nk_q    <= nk_res_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.build_step) begin
			mem[idx_q] <= gen_next;
		end
		rd_q <= mem[rd_addr];
	end

endmodule

`default_nettype wire

FILE: sv/xtsd_ctrl.sv
// ----------------------------------------------------------------------------
// xtsd_ctrl
// Sequencer for capture, table build, table reads and result transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module xtsd_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output      logic           in_ready,
	output      logic           out_valid,
	input  wire logic           out_ready,
	input  wire xtsd_pkg::sts_t sts,
	output      xtsd_pkg::ctl_t ctl
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_BUILD = 5'b00010,
		ST_READ  = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_next     = state_q;
		ctl.capture    = 1'b0;
		ctl.build_step = 1'b0;
		ctl.read_step  = 1'b0;
		ctl.push       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctl.capture = 1'b1;
					if (sts.go_build) begin
						state_next = ST_BUILD;
					end else if (sts.go_read) begin
						state_next = ST_READ;
					end else begin
						state_next = ST_DONE;
					end
				end
			end
			ST_BUILD: begin
				ctl.build_step = 1'b1;
				if (sts.build_last) begin
					state_next = ST_DONE;
				end
			end
			ST_READ: begin
				ctl.read_step = 1'b1;
				if (sts.read_last) begin
					state_next = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// The last table word lands in the key during this cycle.
				state_next = ST_DONE;
			end
			ST_DONE: begin
				if (slot_free) begin
					ctl.push   = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (ctl.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: dv/xtsd_decrypt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtsd_decrypt_checker
// Watches the command and result channels of the stream decryptor. It keeps
// its own running key and key table, works out the plaintext for every
// accepted command, and compares each result transfer with the oldest
// outstanding plaintext.
// ----------------------------------------------------------------------------

module xtsd_decrypt_checker (
	input wire logic clk,
	input wire logic arst_n,
	xtsd_cmd_if      cmd_ch,
	xtsd_res_if      res_ch,
	output int       mismatch_count,
	output int       pending_count,
	output int       checked_count
);
	import xtsd_pkg::*;

	typedef struct packed {
		logic [31:0] plain_data;
		logic        no_key;
	} plain_t;

	plain_t      plain_q[$];
	logic [31:0] key_r;
	logic [31:0] table_r [TABLE_N];
	logic        loaded_r;

	always @(posedge clk or negedge arst_n) begin
		plain_t      want;
		logic [31:0] k;
		logic [31:0] c;
		if (!arst_n) begin
			key_r = '0;
			loaded_r = 1'b0;
			plain_q.delete();
			mismatch_count = 0;
			checked_count = 0;
			pending_count = 0;
		end else begin
			// Results are checked before the new command is queued. A result passes
			// through the capture and output registers, so it never belongs to a command
			// accepted at the same edge.
			if (res_ch.valid && res_ch.ready) begin
				if (plain_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"[%0t] result with nothing outstanding: ",
							"plain_data=%08h no_key=%0b"},
							$realtime, res_ch.plain_data, res_ch.no_key);
				end else begin
					want = plain_q.pop_front();
					checked_count++;
					if (res_ch.plain_data !== want.plain_data ||
					    res_ch.no_key !== want.no_key) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display({"[%0t] result %0d: expected plain_data=%08h ",
								"no_key=%0b, got plain_data=%08h no_key=%0b"},
								$realtime, checked_count, want.plain_data,
								want.no_key, res_ch.plain_data, res_ch.no_key);
					end
				end
			end

			if (cmd_ch.valid && cmd_ch.ready) begin
				c = cmd_ch.cipher_data;
				want = '0;
				if (cmd_ch.command == CMD_LOAD) begin
					k = c ^ KEY_WHITEN;
					key_r = k;
					for (int i = 0; i < TABLE_N; i++) begin
						k = {k[0], k[31:1]} * TABLE_MULT;
						table_r[i] = k;
					end
					loaded_r = 1'b1;
					want.plain_data = key_r;
				end else if (!loaded_r) begin
					want.no_key = 1'b1;
				end else begin
					case (cmd_ch.command)
					CMD_WORD_UPD: begin
						want.plain_data = c ^ key_r;
						key_r = key_r ^ table_r[c[7:0]] ^ table_r[c[15:8]]
							^ table_r[c[23:16]] ^ table_r[c[31:24]];
					end
					CMD_BYTE_UPD: begin
						want.plain_data = {24'h0, c[7:0] ^ key_r[7:0]};
						key_r = key_r ^ table_r[c[7:0]];
					end
					default: begin
						want.plain_data = c ^ key_r;
					end
					endcase
				end
				plain_q = {plain_q, want};
			end
			pending_count = plain_q.size();
		end
	end

endmodule

FILE: dv/xor_table_stream_decryptor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_table_stream_decryptor_tb
// Drives key loads, word and byte decryption commands into the stream
// decryptor, first a directed set around missing keys, reloads and edge
// values, then random key-chained streams, with random stalls on both sides.
// A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------

module xor_table_stream_decryptor_tb;
	import xtsd_pkg::*;

	logic clk;
	logic arst_n;
	logic calm;
	int   gap_odds;
	int   op_count [4];
	int   mismatch_count;
	int   pending_count;
	int   checked_count;

	xtsd_cmd_if cmd_ch ();
	xtsd_res_if res_ch ();

	xor_table_stream_decryptor i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_ch (cmd_ch),
		.res_ch (res_ch)
	);

	xtsd_decrypt_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_ch         (cmd_ch),
		.res_ch         (res_ch),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count),
		.checked_count  (checked_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_500_000;
		$display("Regression FAIL");
		$finish;
	end

	// Offers one command and returns at the edge where it is transferred.
	task automatic send_cmd(input logic [1:0] op, input logic [31:0] word);
		int gap;
		gap = 0;
		if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0)
			gap = $urandom_range(1, 18);
		if (gap != 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid       <= 1'b1;
		cmd_ch.command     <= op;
		cmd_ch.cipher_data <= word;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		op_count[op]++;
	endtask

	// Result side: stalls come in bursts, with quiet stretches in between.
	initial begin
		int stall_odds;
		int cycle;
		stall_odds = 0;
		cycle = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (cycle % 256 == 0) begin
				case ($urandom_range(0, 2))
				0: stall_odds = 0;
				1: stall_odds = 4;
				default: stall_odds = 12;
				endcase
			end
			cycle++;
			if (!calm && stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				cycle++;
			end
			res_ch.ready <= 1'b1;
		end
	end

	initial begin
		logic [1:0]  op;
		logic [31:0] word;
		int          pick;
		int          drain;

		arst_n             = 1'b0;
		calm               = 1'b0;
		gap_odds           = 4;
		cmd_ch.valid       = 1'b0;
		cmd_ch.command     = CMD_LOAD;
		cmd_ch.cipher_data = '0;
		res_ch.ready       = 1'b0;
		foreach (op_count[i]) op_count[i] = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Commands before any key are ignored and flagged.
		send_cmd(CMD_WORD_UPD, 32'hffff_ffff);
		send_cmd(CMD_BYTE_UPD, 32'h0000_00ff);
		send_cmd(CMD_WORD,     32'h0000_0000);
		// This raw key whitens to an all-zero working key.
		send_cmd(CMD_LOAD,     32'h5555_5555);
		send_cmd(CMD_WORD,     32'hffff_ffff);
		// Four equal cipher bytes cancel in the key update.
		send_cmd(CMD_WORD_UPD, 32'h0000_0000);
		send_cmd(CMD_WORD_UPD, 32'hffff_ffff);
		send_cmd(CMD_WORD_UPD, 32'h1234_5678);
		// The byte command must ignore the upper 24 bits.
		send_cmd(CMD_BYTE_UPD, 32'hffff_ff00);
		send_cmd(CMD_BYTE_UPD, 32'h0000_00ff);
		send_cmd(CMD_WORD,     32'ha5a5_a5a5);
		send_cmd(CMD_LOAD,     32'hffff_ffff);
		send_cmd(CMD_WORD_UPD, 32'h8000_0001);
		send_cmd(CMD_BYTE_UPD, 32'hdead_be80);
		send_cmd(CMD_LOAD,     32'h0000_0000);
		send_cmd(CMD_WORD,     32'h0000_0000);
		send_cmd(CMD_WORD_UPD, 32'habab_abab);
		send_cmd(CMD_BYTE_UPD, 32'h0000_007f);

		for (int n = 0; n < 632; n++) begin
			if (n % 40 == 0) begin
				case ($urandom_range(0, 2))
				0: gap_odds = 0;
				1: gap_odds = 2;
				default: gap_odds = 5;
				endcase
			end
			if (n >= 560)
				calm = 1'b1;

			// Mostly chained streams under one key, with a rare reload.
			pick = $urandom_range(0, 99);
			if (pick < 4)
				op = CMD_LOAD;
			else if (pick < 45)
				op = CMD_WORD_UPD;
			else if (pick < 75)
				op = CMD_BYTE_UPD;
			else
				op = CMD_WORD;

			pick = $urandom_range(0, 9);
			if (pick < 8)
				word = $urandom;
			else if (pick == 8)
				word = {4{8'($urandom_range(0, 255))}};
			else
				word = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0000_0000;
			send_cmd(op, word);
		end
		cmd_ch.valid <= 1'b0;
		@(posedge clk);

		while (pending_count != 0) @(posedge clk);
		// A load holds the block for a full table rebuild.
		drain = 300;
		repeat (drain) @(posedge clk);

		$display("Sent %0d key loads, %0d updating words, %0d updating bytes, %0d plain words.",
			op_count[CMD_LOAD], op_count[CMD_WORD_UPD], op_count[CMD_BYTE_UPD],
			op_count[CMD_WORD]);
		$display("Checked %0d results, %0d mismatches, %0d left outstanding.",
			checked_count, mismatch_count, pending_count);
		if (mismatch_count == 0 && pending_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
